// ----- sv/rmsd_pkg.sv -----
package rmsd_pkg;

  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 64;

  localparam int PIX_IDX_W = 12;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int ROW_SEL_W = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OE_DWELL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 1'd1;

  localparam logic [CFG_W-1:0] OE_DWELL_RST  = 16'd30;
  localparam logic [CFG_W-1:0] FRAME_GAP_RST = 16'd10000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic                 lower;
    logic [PIX_IDX_W-1:0] addr;
    logic [2:0]           rgb;
  } cmd_t;

  // pin levels, lowest bit first: up rgb, lo rgb, row, sclk, lat, oe_n
  typedef struct packed {
    logic                 oe_n;
    logic                 lat;
    logic                 sclk;
    logic [ROW_SEL_W-1:0] row;
    logic [2:0]           lo;
    logic [2:0]           up;
  } pins_t;

endpackage

// ----- sv/rmsd_front.sv -----
module rmsd_front #(
  parameter int PANEL_WIDTH  = rmsd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rmsd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rmsd_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rmsd_pkg::OP_W-1:0]      s_tuser,
  input  logic                           q_full,
  input  logic                           clearing,
  output logic                           q_push,
  output rmsd_pkg::cmd_t                 q_cmd
);
  import rmsd_pkg::*;

  localparam int PIXEL_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int HALF_PIX    = PIXEL_COUNT / 2;

  logic [PIX_IDX_W-1:0] idx;
  logic [BYTE_W-1:0]    red, green, blue;
  logic                 lower;

  assign idx   = s_tdata[PIX_IDX_W-1:0];
  assign red   = s_tdata[PIX_IDX_W +: BYTE_W];
  assign green = s_tdata[PIX_IDX_W+BYTE_W +: BYTE_W];
  assign blue  = s_tdata[PIX_IDX_W+2*BYTE_W +: BYTE_W];
  assign lower = 32'(idx) >= HALF_PIX;

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd.op       = op_t'(s_tuser);
    q_cmd.in_range = 32'(idx) < PIXEL_COUNT;
    q_cmd.lower    = lower;
    q_cmd.addr     = lower ? PIX_IDX_W'(32'(idx) - HALF_PIX) : idx;
    q_cmd.rgb      = {|blue, |green, |red};
  end

endmodule

// ----- sv/rmsd_queue.sv -----
module rmsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rmsd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rmsd_pkg::cmd_t head
);
  import rmsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign full      = count == NW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

// ----- sv/rmsd_back.sv -----
module rmsd_back #(
  parameter int PANEL_WIDTH  = rmsd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rmsd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  rmsd_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  input  logic [rmsd_pkg::CFG_W-1:0]     oe_dwell,
  input  logic [rmsd_pkg::CFG_W-1:0]     frame_gap,
  output logic                           clearing,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rmsd_pkg::M_TDATA_W-1:0] m_tdata  // up r,g,b, lo r,g,b, row[4:0], sclk, lat, oe_n, enabled
);
  import rmsd_pkg::*;

  localparam int HALF_ROWS = PANEL_HEIGHT / 2;
  localparam int HALF_PIX  = HALF_ROWS * PANEL_WIDTH;
  localparam int AW        = $clog2(HALF_PIX);
  localparam int CW        = $clog2(PANEL_WIDTH);
  localparam int RW        = $clog2(HALF_ROWS);

  typedef enum logic [7:0] {
    PH_SHIFT_LOW  = 8'b0000_0001,
    PH_SHIFT_HIGH = 8'b0000_0010,
    PH_ADDRESS    = 8'b0000_0100,
    PH_LATCH_HIGH = 8'b0000_1000,
    PH_LATCH_LOW  = 8'b0001_0000,
    PH_OE_ACTIVE  = 8'b0010_0000,
    PH_OE_OFF     = 8'b0100_0000,
    PH_GAP        = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    BS_CLEAR = 3'b001,
    BS_RUN   = 3'b010,
    BS_READ  = 3'b100
  } bstate_t;

  logic [2:0] mem_up [HALF_PIX];
  logic [2:0] mem_lo [HALF_PIX];
  logic [2:0] rd_up, rd_lo;

  bstate_t       st, st_next;
  phase_t        phase, phase_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] rp, rp_next;
  logic [15:0]   dwell, dwell_next;
  logic [16:0]   dwell_inc;
  logic [AW-1:0] clr_addr;
  logic          enabled, enabled_next;
  pins_t         pins, pins_next;

  logic          out_free, run_cmd, rd_en, tick_do;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we_up, we_lo;
  logic [2:0]    wr_data;

  assign out_free = !m_tvalid || m_tready;
  assign run_cmd  = (st == BS_RUN) && cmd_valid && out_free;
  assign rd_en    = run_cmd && (cmd.op == OP_TICK) && (phase == PH_SHIFT_LOW);
  assign cmd_pop  = (run_cmd && !rd_en) || ((st == BS_READ) && out_free);
  assign tick_do  = cmd_pop && (cmd.op == OP_TICK);
  assign clearing = st == BS_CLEAR;

  assign rd_addr   = AW'(32'(rp) * PANEL_WIDTH + 32'(col));
  assign dwell_inc = {1'b0, dwell} + 17'd1;

  assign wr_addr = clearing ? clr_addr : AW'(cmd.addr);
  assign wr_data = clearing ? 3'b000 : cmd.rgb;
  assign we_up   = clearing
                || (cmd_pop && cmd.op == OP_WRITE && cmd.in_range && !cmd.lower);
  assign we_lo   = clearing
                || (cmd_pop && cmd.op == OP_WRITE && cmd.in_range && cmd.lower);

  always_ff @(posedge clk) begin
    if (we_up) begin
      mem_up[wr_addr] <= wr_data;
    end
    if (we_lo) begin
      mem_lo[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_up <= mem_up[rd_addr];
      rd_lo <= mem_lo[rd_addr];
    end
  end

  // scan sequencer, at most one phase per tick; the OE and gap phases hold until their dwell count is reached
  always_comb begin
    phase_next = phase;
    col_next   = col;
    rp_next    = rp;
    dwell_next = dwell;
    pins_next  = pins;
    if (tick_do) begin
      case (phase)
        PH_SHIFT_LOW: begin
          pins_next.up   = rd_up;
          pins_next.lo   = rd_lo;
          pins_next.sclk = 1'b0;
          phase_next     = PH_SHIFT_HIGH;
        end
        PH_SHIFT_HIGH: begin
          pins_next.sclk = 1'b1;
          if (col == CW'(PANEL_WIDTH - 1)) begin
            col_next   = '0;
            phase_next = PH_ADDRESS;
          end else begin
            col_next   = col + 1'b1;
            phase_next = PH_SHIFT_LOW;
          end
        end
        PH_ADDRESS: begin
          pins_next.row = ROW_SEL_W'(rp);
          phase_next    = PH_LATCH_HIGH;
        end
        PH_LATCH_HIGH: begin
          pins_next.lat = 1'b1;
          phase_next    = PH_LATCH_LOW;
        end
        PH_LATCH_LOW: begin
          pins_next.lat = 1'b0;
          dwell_next    = '0;
          phase_next    = PH_OE_ACTIVE;
        end
        PH_OE_ACTIVE: begin
          pins_next.oe_n = 1'b0;
          if (dwell_inc >= {1'b0, oe_dwell}) begin
            dwell_next = '0;
            phase_next = PH_OE_OFF;
          end else begin
            dwell_next = dwell_inc[15:0];
          end
        end
        PH_OE_OFF: begin
          pins_next.oe_n = 1'b1;
          if (rp == RW'(HALF_ROWS - 1)) begin
            rp_next    = '0;
            dwell_next = '0;
            phase_next = (frame_gap == '0) ? PH_SHIFT_LOW : PH_GAP;
          end else begin
            rp_next    = rp + 1'b1;
            phase_next = PH_SHIFT_LOW;
          end
        end
        default: begin
          if (dwell_inc >= {1'b0, frame_gap}) begin
            dwell_next = '0;
            phase_next = PH_SHIFT_LOW;
          end else begin
            dwell_next = dwell_inc[15:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    enabled_next = enabled;
    if (cmd_pop && cmd.op == OP_ENABLE) begin
      enabled_next = 1'b1;
    end else if (cmd_pop && cmd.op == OP_DISABLE) begin
      enabled_next = 1'b0;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      BS_CLEAR: begin
        if (clr_addr == AW'(HALF_PIX - 1)) begin
          st_next = BS_RUN;
        end
      end
      BS_RUN: begin
        if (rd_en) begin
          st_next = BS_READ;
        end else if (cmd_pop && cmd.op == OP_DISABLE) begin
          st_next = BS_CLEAR;
        end
      end
      BS_READ: begin
        if (out_free) begin
          st_next = BS_RUN;
        end
      end
      default: st_next = BS_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= BS_CLEAR;
      clr_addr <= '0;
      phase    <= PH_SHIFT_LOW;
      col      <= '0;
      rp       <= '0;
      dwell    <= '0;
      enabled  <= 1'b0;
      pins     <= '{oe_n: 1'b1, lat: 1'b0, sclk: 1'b1, row: '0, lo: '0, up: '0};
      m_tvalid <= 1'b0;
    end else begin
      st       <= st_next;
      clr_addr <= clearing ? clr_addr + 1'b1 : '0;
      phase    <= phase_next;
      col      <= col_next;
      rp       <= rp_next;
      dwell    <= dwell_next;
      enabled  <= enabled_next;
      pins     <= pins_next;
      if (cmd_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      m_tdata <= {1'b0, enabled_next, pins_next};
    end
  end

`ifndef SYNTHESIS
  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> out_free)
    else $error("beat emitted over a pending result");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (st == BS_READ) |-> cmd_pop)
    else $error("store read not completed next cycle");

  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.op == OP_DISABLE) |=> (st == BS_CLEAR && clr_addr == '0))
    else $error("disable did not start a clear sweep");

  a_latch_phase: assert property (@(posedge clk) disable iff (rst)
    pins.lat |-> (phase == PH_LATCH_LOW))
    else $error("latch high outside latch phase");

  a_oe_phase: assert property (@(posedge clk) disable iff (rst)
    !pins.oe_n |-> (phase == PH_OE_ACTIVE || phase == PH_OE_OFF))
    else $error("output enable active outside dwell");
`endif

endmodule

// ----- sv/rgb_matrix_scan_driver.sv -----
// Path: an accepted beat passes the queue, then the output register; a shift-low tick
//   also waits on the registered frame store read, which holds the next beat back.
// Flow: one beat per cycle unless m_tready stalls the output; a disable starts a clear
//   sweep of PANEL_WIDTH*PANEL_HEIGHT/2 store addresses (2048 at 64x64).
// Reset: synchronous; the same clear sweep runs after reset with s_tready low.
module rgb_matrix_scan_driver #(
  parameter int PANEL_WIDTH  = rmsd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rmsd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rmsd_pkg::S_TDATA_W-1:0] s_tdata,  // pixel_index, red, green, blue
  input  logic [rmsd_pkg::OP_W-1:0]      s_tuser,  // operation
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rmsd_pkg::M_TDATA_W-1:0] m_tdata,  // up r,g,b, lo r,g,b, row, sclk, lat, oe_n, en
  input  logic                           cfg_we,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmsd_pkg::CFG_W-1:0]     cfg_data
);
  import rmsd_pkg::*;

  logic [CFG_W-1:0] oe_dwell, frame_gap;
  logic             q_full, q_push, q_pop, q_not_empty, clearing;
  cmd_t             q_in, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      oe_dwell  <= OE_DWELL_RST;
      frame_gap <= FRAME_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OE_DWELL:  oe_dwell  <= cfg_data;
        REG_FRAME_GAP: frame_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  rmsd_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  rmsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rmsd_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .oe_dwell  (oe_dwell),
    .frame_gap (frame_gap),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
